// ===== src/rrle_pkg.sv =====
// ----------------------------------------------------------------------------
// rrle_pkg - shared types and constants for the raster row RLE decoder
// Request payloads, register indexes and opcode values.
// ----------------------------------------------------------------------------
package rrle_pkg;

    localparam int MAX_WIDTH_DEFAULT = 4096;

    localparam int REG_W     = 13;   // widest configuration register
    localparam int FIELD_W   = 13;   // start_column / span_length
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_WIDE_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH = 1'b1;

    localparam logic [REG_W-1:0] ROW_WIDTH_RESET = 13'd1024;

    localparam logic OP_DATA = 1'b0;
    localparam logic OP_EOR  = 1'b1;

    localparam logic [3:0] NIBBLE_MASK = 4'hf;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
    } code_req_t;

    typedef struct packed {
        logic [FIELD_W-1:0] start_column;
        logic [FIELD_W-1:0] span_length;
        logic [7:0]         pixel_value;
        logic               end_of_row;
        logic               format_error;
    } span_req_t;

endpackage

// ===== src/rrle_stream_if.sv =====
// ----------------------------------------------------------------------------
// rrle_stream_if - valid/ready channel
// Carries one request payload of type T per accepted handshake.
// ----------------------------------------------------------------------------
interface rrle_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/raster_row_rle_decoder_core.sv =====
// ----------------------------------------------------------------------------
// raster_row_rle_decoder_core - run-length decoder for raster image rows
// Turns coded row bytes and end-of-row markers into pixel spans.
// ----------------------------------------------------------------------------
// Usage:
//   coded : sink channel, one request per coded byte (op = data) or per
//           end-of-row marker (op = end of row).
//   spans : source channel, at most one span request per coded request.
//   cfg_* : register writes (wide_mode, row_width), only while idle.
// Timing: a span appears on spans in the cycle after its coded request is
//   accepted. Throughput: one coded request per cycle while spans is not
//   stalled; the column counter update is a single add and compare, and
//   the span sits in one output register.
// A first byte of a wide pair and any request after a format error give
//   no span. The format error is sticky until reset.
// Stall: while spans is stalled with a span waiting, coded.ready drops;
//   it follows spans.ready combinationally, so no cycle is lost.
// Reset: column, pending pair and error state clear; wide_mode = 0,
//   row_width = 1024; the output register is empty.
// ----------------------------------------------------------------------------
module raster_row_rle_decoder_core #(
    parameter int MAX_WIDTH = rrle_pkg::MAX_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [rrle_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rrle_pkg::REG_W-1:0]     cfg_data,
    rrle_stream_if.sink                    coded,
    rrle_stream_if.source                  spans
);
    import rrle_pkg::*;

    // column never passes MAX_WIDTH + 255
    localparam int CW = $clog2(MAX_WIDTH + 256);
    localparam int XW = (CW > REG_W) ? CW : REG_W;
    localparam logic [XW-1:0] MAX_W_X = XW'(MAX_WIDTH);

    logic              wide_mode_reg;
    logic [REG_W-1:0]  row_width_reg;
    logic [CW-1:0]     column_reg, column_next;
    logic [7:0]        pend_run_reg, pend_run_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              error_reg, error_next;
    logic              out_valid_reg, out_valid_next;
    span_req_t         out_data_reg;

    logic              acc_in;
    logic              res_valid;
    span_req_t         res;
    logic [XW-1:0]     width_x;
    logic [XW-1:0]     col_x;
    logic [XW-1:0]     pad_len;
    logic [7:0]        run;
    logic [7:0]        color;
    logic [CW-1:0]     col_sum;

    assign acc_in      = coded.valid && coded.ready;
    assign coded.ready = !out_valid_reg || spans.ready;
    assign spans.valid = out_valid_reg;
    assign spans.data  = out_data_reg;

    // effective width clamps to MAX_WIDTH
    assign width_x = (XW'(row_width_reg) > MAX_W_X) ? MAX_W_X : XW'(row_width_reg);
    assign col_x   = XW'(column_reg);
    assign pad_len = (col_x < width_x) ? (width_x - col_x) : '0;
    assign col_sum = column_reg + CW'(run);

    always_comb
    begin
        if (wide_mode_reg && pend_valid_reg)
        begin
            run   = pend_run_reg;
            color = coded.data.data_byte;
        end
        else
        begin
            run   = {4'h0, coded.data.data_byte[7:4]};
            color = {4'h0, coded.data.data_byte[3:0] & NIBBLE_MASK};
        end
    end

    always_comb
    begin
        column_next     = column_reg;
        pend_run_next   = pend_run_reg;
        pend_valid_next = pend_valid_reg;
        error_next      = error_reg;
        res_valid       = 1'b0;
        res             = '0;
        res.start_column = FIELD_W'(column_reg);

        if (acc_in && !error_reg)
        begin
            if (coded.data.op == OP_EOR)
            begin
                res_valid       = 1'b1;
                res.span_length = pad_len[FIELD_W-1:0];
                res.end_of_row  = 1'b1;
                column_next     = '0;
                pend_run_next   = '0;
                pend_valid_next = 1'b0;
            end
            else if (wide_mode_reg && !pend_valid_reg)
            begin
                pend_run_next   = coded.data.data_byte;
                pend_valid_next = 1'b1;
            end
            else
            begin
                res_valid = 1'b1;
                if (wide_mode_reg)
                begin
                    pend_valid_next = 1'b0;
                end
                if (col_x > width_x)
                begin
                    error_next       = 1'b1;
                    res.format_error = 1'b1;
                end
                else
                begin
                    res.span_length = FIELD_W'(run);
                    res.pixel_value = color;
                    column_next     = col_sum;
                end
            end
        end
    end

    always_comb
    begin
        if (res_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (spans.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_mode_reg  <= 1'b0;
            row_width_reg  <= ROW_WIDTH_RESET;
            column_reg     <= '0;
            pend_run_reg   <= '0;
            pend_valid_reg <= 1'b0;
            error_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            column_reg     <= column_next;
            pend_run_reg   <= pend_run_next;
            pend_valid_reg <= pend_valid_next;
            error_reg      <= error_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WIDE_MODE: wide_mode_reg <= cfg_data[0];
                    REG_ROW_WIDTH: row_width_reg <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
        begin
            out_data_reg <= res;
        end
    end

    // error report goes out as a span request with the flag set
    a_err_reported: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(error_reg) |-> (spans.valid && spans.data.format_error))
        else $error("format error latched without a flagged span");

    // narrow bytes never open a wide pair
    a_narrow_no_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_in && !error_reg && coded.data.op == OP_DATA && !wide_mode_reg
         && !pend_valid_reg) |=> !pend_valid_reg)
        else $error("pending pair set in narrow mode");

    // end of row restarts the column
    a_eor_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_in && !error_reg && coded.data.op == OP_EOR)
        |=> (column_reg == '0 && !pend_valid_reg
             && spans.valid && spans.data.end_of_row))
        else $error("end of row did not restart the row");

    // once latched, nothing new reaches the output register
    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(error_reg) && error_reg && !$past(out_valid_reg)) |-> !out_valid_reg)
        else $error("span produced after format error");

endmodule
